@@ hw/rtl/rx_fifo_with_xon_xoff_assert.svh @@
// Assertion macros for the receive buffer with XON/XOFF flow control.
// Depends on nothing; included by the top level.
`ifndef RX_FIFO_WITH_XON_XOFF_ASSERT_SVH
`define RX_FIFO_WITH_XON_XOFF_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define RXF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent is followed by the consequent in the next cycle.
`define RXF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define RXF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rxf_pkg.sv @@
// Types and constants of the receive buffer with XON/XOFF flow control.
// Depends on nothing.
`timescale 1ns / 1ps

package rxf_pkg;

  localparam int unsigned FILL_W = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PORT_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_XON_EN  = 1'b1;

  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [7:0] XON_CODE  = 8'd1;
  localparam logic [7:0] XOFF_CODE = 8'd0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } rxf_in_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              read_valid;
    logic              data_ready;
    logic              tx_pause;
    logic              overflow;
    logic [FILL_W-1:0] fill_count;
  } rxf_out_t;

endpackage

@@ hw/rtl/rxf_ram.sv @@
// Byte store of the receive buffer: one write port, one read port,
// read data registered. Depends on nothing.
`timescale 1ns / 1ps

module rxf_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/rx_fifo_with_xon_xoff.sv @@
// Top level of the receive buffer with XON/XOFF flow control.
// Depends on rxf_pkg, rxf_ram and rx_fifo_with_xon_xoff_assert.svh.
`timescale 1ns / 1ps

// Each input beat is either a byte from the line or a host read, and each
// gives exactly one result beat. Received bytes, reads from an empty buffer
// and any beat while the port is disabled give their result in the cycle
// after they are taken, so they can follow each other on every clock while
// the output is not stalled. A read that pops a byte holds off new beats in
// a busy state while the byte comes out of the registered RAM read port
// into the result register. The byte store needs no clearing after reset;
// the fill count keeps unwritten entries from being read.
module rx_fifo_with_xon_xoff #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rxf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rxf_pkg::rxf_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rxf_pkg::rxf_out_t             out_data_o
);

  import rxf_pkg::*;

  `include "rx_fifo_with_xon_xoff_assert.svh"

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             port_en_q, xon_en_q;
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pause_q, pause_d, ovf_q, ovf_d;
  logic             busy_q, busy_d, out_valid_q, out_valid_d;
  rxf_out_t         res_q, res_d;
  logic             accept, we, re, is_code;
  logic [7:0]       rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q | (out_valid_q & out_stall_i);
  assign accept      = in_valid_i & ~in_stall_o;
  assign is_code     = (in_data_i.rx_byte == XON_CODE) || (in_data_i.rx_byte == XOFF_CODE);

  rxf_ram #(
    .DEPTH(DEPTH),
    .WIDTH(8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wptr_q),
    .wdata_i(in_data_i.rx_byte),
    .re_i   (re),
    .raddr_i(rptr_q),
    .rdata_o(rdata)
  );

  always_comb begin
    wptr_d      = wptr_q;
    rptr_d      = rptr_q;
    cnt_d       = cnt_q;
    pause_d     = pause_q;
    ovf_d       = ovf_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    we          = 1'b0;
    re          = 1'b0;
    if (busy_q) begin
      res_d.read_data = rdata;
      out_valid_d     = 1'b1;
      busy_d          = 1'b0;
    end else if (accept) begin
      if (port_en_q) begin
        if (in_data_i.req_type == REQ_RX) begin
          if (cnt_q == CNT_W'(DEPTH)) begin
            ovf_d = 1'b1;
          end else if (xon_en_q && is_code) begin
            pause_d = (in_data_i.rx_byte == XOFF_CODE);
            ovf_d   = 1'b0;
          end else begin
            we      = 1'b1;
            wptr_d  = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
            cnt_d   = cnt_q + 1'b1;
            pause_d = 1'b0;
            ovf_d   = 1'b0;
          end
        end else if (cnt_q != '0) begin
          re     = 1'b1;
          rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
          cnt_d  = cnt_q - 1'b1;
        end
      end
      res_d.read_data  = 8'd0;
      res_d.read_valid = re;
      res_d.data_ready = port_en_q && (cnt_d != '0);
      res_d.tx_pause   = pause_d;
      res_d.overflow   = ovf_d;
      res_d.fill_count = FILL_W'(cnt_d);
      busy_d           = re;
      out_valid_d      = ~re;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_en_q   <= 1'b0;
      xon_en_q    <= 1'b0;
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      pause_q     <= 1'b0;
      ovf_q       <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_PORT_EN: port_en_q <= cfg_data_i;
          REG_XON_EN:  xon_en_q  <= cfg_data_i;
          default: ;
        endcase
      end
      wptr_q      <= wptr_d;
      rptr_q      <= rptr_d;
      cnt_q       <= cnt_d;
      pause_q     <= pause_d;
      ovf_q       <= ovf_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `RXF_ASSERT_NEXT(a_pop_completes, clk_i, rst_ni, busy_q, out_valid_q && !busy_q, "pop did not complete")
  `RXF_ASSERT_ALWAYS(a_no_busy_with_result, clk_i, rst_ni, !(busy_q && out_valid_q), "result held during pop")
  `RXF_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH), "fill count above depth")
  `RXF_ASSERT_IMPLIES(a_pop_needs_data, clk_i, rst_ni, re, cnt_q != '0 && port_en_q, "pop from empty buffer")

endmodule
